### rtl/encoder_word_check_and_turn_unwrap_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the encoder word check and turn unwrap block
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ENCODER_WORD_CHECK_AND_TURN_UNWRAP_ASSERT_SVH
`define ENCODER_WORD_CHECK_AND_TURN_UNWRAP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EWCTU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define EWCTU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked while reset is high.
`define EWCTU_ASSERT_RESET(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/ewctu_pkg.sv
// ----------------------------------------------------------------------------
// Encoder word check and turn unwrap package
// Shared widths, constants and the structs passed between the modules.
// ----------------------------------------------------------------------------
package ewctu_pkg;

  // Number of encoder channels kept in the position state.
  localparam int CHANNELS = 4;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths of one transfer.
  localparam int CHAN_W  = 2;
  localparam int WORD_W  = 16;
  localparam int ANGLE_W = 12;
  localparam int POS_W   = 32;

  // Signed difference of two angles is held with two bits above the angle.
  localparam int DIFF_W    = ANGLE_W + 2;
  localparam int TURN      = 4096;
  localparam int HALF_TURN = 2048;

  // Result of checking one reply word.
  typedef struct packed {
    logic               good;
    logic [ANGLE_W-1:0] angle;
  } check_t;

  // One result item.
  typedef struct packed {
    logic                    valid_res;
    logic signed [POS_W-1:0] position;
    logic [ANGLE_W-1:0]      angle;
  } res_t;

endpackage

### rtl/ewctu_word_check.sv
// ----------------------------------------------------------------------------
// Reply word check
// Tests both odd-parity check bits and extracts the 12-bit angle.
// ----------------------------------------------------------------------------
module ewctu_word_check import ewctu_pkg::*; (
  input  logic              received,
  input  logic [WORD_W-1:0] raw_word,
  output check_t            chk
);

  logic odd_group;
  logic even_group;

  // Bit 15 covers the odd data bits, bit 14 the even ones; each group is odd.
  always_comb begin
    odd_group  = raw_word[15];
    even_group = raw_word[14];
    for (int i = 0; i < 14; i += 2) begin
      even_group = even_group ^ raw_word[i];
      odd_group  = odd_group ^ raw_word[i+1];
    end
  end

  // The angle sits in data bits 13 down to 2.
  assign chk.good  = received & odd_group & even_group;
  assign chk.angle = raw_word[13:2];

endmodule

### rtl/ewctu_unwrap.sv
// ----------------------------------------------------------------------------
// Multi-turn unwrap
// Holds the per-channel angle and position; applies one good word a cycle on upd.
// ----------------------------------------------------------------------------
module ewctu_unwrap import ewctu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              upd,
  input  logic [CHAN_W-1:0] channel,
  input  check_t            chk,
  output res_t              res
);

  logic [ANGLE_W-1:0]      last_angle [CHANNELS];
  logic signed [POS_W-1:0] turn_position [CHANNELS];

  logic                     ch_ok;
  logic [CH_W-1:0]          idx;
  logic [ANGLE_W-1:0]       last_cur;
  logic signed [POS_W-1:0]  pos_cur;
  logic signed [DIFF_W-1:0] diff_raw;
  logic signed [DIFF_W-1:0] diff;
  logic signed [POS_W-1:0]  pos_next;
  logic                     take;

  // Select the channel's current state.
  assign ch_ok    = 32'(channel) < 32'(CHANNELS);
  assign idx      = CH_W'(channel);
  assign last_cur = ch_ok ? last_angle[idx] : '0;
  assign pos_cur  = ch_ok ? turn_position[idx] : '0;
  assign take     = ch_ok & chk.good;

  // Wrap the angle step into a half turn either way; exactly half stays as is.
  always_comb begin
    diff_raw = $signed({2'b00, chk.angle}) - $signed({2'b00, last_cur});
    if (diff_raw > $signed(DIFF_W'(HALF_TURN))) begin
      diff = diff_raw - $signed(DIFF_W'(TURN));
    end else if (diff_raw < -$signed(DIFF_W'(HALF_TURN))) begin
      diff = diff_raw + $signed(DIFF_W'(TURN));
    end else begin
      diff = diff_raw;
    end
  end

  assign pos_next = pos_cur + {{(POS_W-DIFF_W){diff[DIFF_W-1]}}, diff};

  // State update on a good word that leaves the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_angle[i]    <= '0;
        turn_position[i] <= '0;
      end
    end else if (upd && take) begin
      last_angle[idx]    <= chk.angle;
      turn_position[idx] <= pos_next;
    end
  end

  // Result reports the state after the step.
  assign res.valid_res = take;
  assign res.position  = take ? pos_next : pos_cur;
  assign res.angle     = take ? chk.angle : last_cur;

endmodule

### rtl/encoder_word_check_and_turn_unwrap.sv
// ----------------------------------------------------------------------------
// Encoder word check and turn unwrap
// Checks absolute encoder reply words and tracks a multi-turn position.
// ----------------------------------------------------------------------------
// Each item is held first in the input register, then in the result register,
// from which the output transfer is made.
// Throughput: one item per cycle while the output is not stalled; the per-channel
// read-modify-write of angle and position between the two registers sets it.
// Reset clears all positions and angles to zero and empties both registers.
module encoder_word_check_and_turn_unwrap import ewctu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] raw_word
  input  logic [2:0]  s_axis_tuser,  // [1:0] channel, [2] received
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [31:0] position, [43:32] angle, [47:44] zero
  output logic [0:0]  m_axis_tuser   // [0] valid_res
);

  logic              in_valid;
  logic [CHAN_W-1:0] in_channel;
  logic              in_received;
  logic [WORD_W-1:0] in_word;
  logic              out_valid;
  res_t              out_res;

  logic   advance;
  logic   in_take;
  check_t chk;
  res_t   res;

  // Handshake: input stage moves on whenever the result register can take it.
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_channel  <= s_axis_tuser[1:0];
      in_received <= s_axis_tuser[2];
      in_word     <= s_axis_tdata;
    end
  end

  ewctu_word_check u_check (
    .received (in_received),
    .raw_word (in_word),
    .chk      (chk)
  );

  ewctu_unwrap u_unwrap (
    .clk     (clk),
    .rst     (rst),
    .upd     (in_valid && advance),
    .channel (in_channel),
    .chk     (chk),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = {4'b0000, out_res.angle, out_res.position};
  assign m_axis_tuser[0] = out_res.valid_res;

endmodule

### rtl/ewctu_checker.sv
// ----------------------------------------------------------------------------
// Port checker for the encoder word check and turn unwrap block
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`include "encoder_word_check_and_turn_unwrap_assert.svh"

module ewctu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // A stalled result transfer holds its contents.
  `EWCTU_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Reset leaves no result pending.
  `EWCTU_ASSERT_RESET(a_reset_empty, clk, rst, !m_axis_tvalid)

  // When the output side takes data the input side is open as well.
  `EWCTU_ASSERT_NOW(a_ready_follows, clk, rst, m_axis_tready, s_axis_tready)

  // A new result appears only for an input transfer that has passed through the input register and the result register.
  `EWCTU_ASSERT_NOW(a_no_invented, clk, rst, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind encoder_word_check_and_turn_unwrap ewctu_checker u_ewctu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### bench/encoder_word_check_and_turn_unwrap_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoder reply checker
// Watches both stream channels of the encoder word check and turn unwrap
// block. For every input transfer it checks the reply word's two parity bits.
// For a received, intact word it unwraps the angle into its own copy of the
// per-channel turn positions. It queues each result that the block must
// return and compares every output transfer with the oldest, field by field.
// ----------------------------------------------------------------------------
module encoder_word_check_and_turn_unwrap_checker import ewctu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] raw_word
  input  logic [2:0]  s_axis_tuser,  // [1:0] channel, [2] received
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,  // [31:0] position, [43:32] angle, [47:44] zero
  input  logic [0:0]  m_axis_tuser,  // [0] valid_res
  output int          failures,
  output int          pending
);

  // Predicted per-channel state.
  logic [ANGLE_W-1:0] last_angle_q [CHANNELS];
  logic [POS_W-1:0]   turn_pos     [CHANNELS];

  // Results still owed by the block, oldest first.
  res_t expected_results [$];
  int   mismatches = 0;

  // Both check bits must give odd parity over their group of data bits.
  function automatic logic reply_intact(logic [WORD_W-1:0] w);
    logic odd_acc;
    logic even_acc;
    int   i;
    odd_acc  = w[15];
    even_acc = w[14];
    for (i = 0; i < 7; i++) begin
      odd_acc  = odd_acc ^ w[2*i+1];
      even_acc = even_acc ^ w[2*i];
    end
    return odd_acc && even_acc;
  endfunction

  // Apply one reply word to the predicted state and return the result it causes.
  function automatic res_t unwrap_reply(int ch, logic rx, logic [WORD_W-1:0] w);
    res_t r;
    int   now_angle;
    int   diff;
    r = '0;
    if (ch >= CHANNELS) return r;
    if (rx && reply_intact(w)) begin
      now_angle = int'(w[13:2]);
      diff = now_angle - int'(last_angle_q[ch]);
      // A step of exactly half a turn is kept as it is.
      if (diff > HALF_TURN) begin
        diff = diff - TURN;
      end else if (diff < -HALF_TURN) begin
        diff = diff + TURN;
      end
      turn_pos[ch]     = turn_pos[ch] + POS_W'(diff);
      last_angle_q[ch] = w[13:2];
      r.valid_res      = 1'b1;
    end
    r.position = turn_pos[ch];
    r.angle    = last_angle_q[ch];
    return r;
  endfunction

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Predict on every input transfer and compare on every output transfer.
  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    int   i;
    if (rst) begin
      for (i = 0; i < CHANNELS; i++) begin
        last_angle_q[i] = '0;
        turn_pos[i]     = '0;
      end
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(
          unwrap_reply(int'(s_axis_tuser[1:0]), s_axis_tuser[2], s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.valid_res = m_axis_tuser[0];
        got.position  = m_axis_tdata[31:0];
        got.angle     = m_axis_tdata[43:32];
        if (expected_results.size() == 0) begin
          $error("result transfer with none expected: valid_res %0d position %0d angle %0d",
                 got.valid_res, got.position, got.angle);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("valid_res", want.valid_res, got.valid_res);
          compare_field("position", want.position, got.position);
          compare_field("angle", want.angle, got.angle);
          compare_field("padding", 0, m_axis_tdata[47:44]);
        end
      end
    end
    pending  <= expected_results.size();
    failures <= mismatches;
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoder word check and turn unwrap testbench
// Sends encoder reply words to the block: a directed set of angle extremes,
// half-turn steps, broken check bits and missing replies, then random walks
// of the angle on all channels with broken and noisy words mixed in. Both
// stream sides idle at random. The checker predicts and compares the results.
// ----------------------------------------------------------------------------
module testbench;
  import ewctu_pkg::*;

  // Ways a generated reply word can be damaged.
  typedef enum int {
    FLAW_NONE,
    FLAW_ODD_CHECK,
    FLAW_EVEN_CHECK,
    FLAW_BOTH_CHECKS,
    FLAW_DATA_BIT
  } flaw_e;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] raw_word
  logic [2:0]  s_axis_tuser;   // [1:0] channel, [2] received
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [31:0] position, [43:32] angle, [47:44] zero
  logic [0:0]  m_axis_tuser;   // [0] valid_res
  int          failures;
  int          pending;
  bit          steady;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  encoder_word_check_and_turn_unwrap DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  encoder_word_check_and_turn_unwrap_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .failures      (failures),
    .pending       (pending)
  );

  // Result side stalls at random, 9 percent of the time on average, except during the steady stretch.
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 9);
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("encoder_word_check_and_turn_unwrap test failed");
    $finish;
  end

  // Build a reply word with correct check bits, then damage it as asked.
  function automatic logic [15:0] build_reply(logic [11:0] ang, logic [1:0] low, flaw_e flaw);
    logic [15:0] w;
    logic        odd_p;
    logic        even_p;
    int          i;
    int          pick;
    w      = {2'b00, ang, low};
    odd_p  = 1'b0;
    even_p = 1'b0;
    for (i = 0; i < 7; i++) begin
      odd_p  = odd_p ^ w[2*i+1];
      even_p = even_p ^ w[2*i];
    end
    w[15] = ~odd_p;
    w[14] = ~even_p;
    case (flaw)
      FLAW_ODD_CHECK: begin
        w[15] = ~w[15];
      end
      FLAW_EVEN_CHECK: begin
        w[14] = ~w[14];
      end
      FLAW_BOTH_CHECKS: begin
        w[15:14] = ~w[15:14];
      end
      FLAW_DATA_BIT: begin
        pick    = $urandom_range(13);
        w[pick] = ~w[pick];
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  // Offer one reply word, after an optional idle gap, and wait for its transfer.
  task automatic send_reply(logic [1:0] ch, logic rx, logic [15:0] word);
    while (!steady && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= {rx, ch};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  initial begin : stimulus
    int          n;
    int          kind;
    int          delta;
    logic [1:0]  ch;
    logic        rx;
    bit          noise;
    flaw_e       flaw;
    logic [11:0] ang;
    logic [15:0] word;
    logic [11:0] walk_angle [CHANNELS];

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    steady        = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Angle extremes and half-turn steps in both directions on channel 0.
    send_reply(2'd0, 1'b1, build_reply(12'd0, 2'b00, FLAW_NONE));
    send_reply(2'd0, 1'b1, build_reply(12'd4095, 2'b11, FLAW_NONE));
    send_reply(2'd0, 1'b1, build_reply(12'd2047, 2'b01, FLAW_NONE));
    send_reply(2'd0, 1'b1, build_reply(12'd4095, 2'b10, FLAW_NONE));
    send_reply(2'd0, 1'b1, build_reply(12'd0, 2'b00, FLAW_NONE));
    send_reply(2'd0, 1'b1, build_reply(12'd2048, 2'b00, FLAW_NONE));
    send_reply(2'd0, 1'b1, build_reply(12'd0, 2'b11, FLAW_NONE));
    // Broken check bits and a missing reply on channel 1.
    send_reply(2'd1, 1'b1, build_reply(12'd100, 2'b01, FLAW_NONE));
    send_reply(2'd1, 1'b1, build_reply(12'd900, 2'b01, FLAW_ODD_CHECK));
    send_reply(2'd1, 1'b1, build_reply(12'd900, 2'b10, FLAW_EVEN_CHECK));
    send_reply(2'd1, 1'b1, build_reply(12'd900, 2'b11, FLAW_BOTH_CHECKS));
    send_reply(2'd1, 1'b1, build_reply(12'd900, 2'b00, FLAW_DATA_BIT));
    send_reply(2'd1, 1'b0, build_reply(12'd900, 2'b00, FLAW_NONE));
    // All-ones and all-zeros words on channel 2.
    send_reply(2'd2, 1'b1, 16'hffff);
    send_reply(2'd2, 1'b1, 16'h0000);
    send_reply(2'd2, 1'b0, 16'hffff);
    send_reply(2'd2, 1'b1, build_reply(12'd4095, 2'b11, FLAW_NONE));
    // Wrap across zero on channel 3.
    send_reply(2'd3, 1'b1, build_reply(12'd4095, 2'b11, FLAW_NONE));
    send_reply(2'd3, 1'b1, build_reply(12'd0, 2'b00, FLAW_NONE));
    send_reply(2'd3, 1'b1, build_reply(12'd4095, 2'b01, FLAW_NONE));
    send_reply(2'd3, 1'b1, build_reply(12'd0, 2'b10, FLAW_NONE));

    walk_angle[0] = 12'd0;
    walk_angle[1] = 12'd100;
    walk_angle[2] = 12'd4095;
    walk_angle[3] = 12'd0;

    // Random walks of the angle, mostly intact words, some broken or noise.
    for (n = 0; n < 1950; n++) begin
      steady = (n >= 800) && (n < 1100);
      ch     = 2'($urandom_range(CHANNELS - 1));
      rx     = ($urandom_range(99) >= 7);
      noise  = ($urandom_range(99) < 6);
      flaw   = ($urandom_range(99) < 14) ? flaw_e'($urandom_range(4, 1)) : FLAW_NONE;
      kind   = $urandom_range(99);
      if (kind < 55) begin
        delta = int'($urandom_range(600)) - 300;
      end else if (kind < 70) begin
        delta = int'($urandom_range(4096)) - 2048;
      end else if (kind < 78) begin
        delta = $urandom_range(1) ? 2048 : -2048;
      end else begin
        delta = $urandom_range(4095);
      end
      ang  = 12'(int'(walk_angle[ch]) + delta);
      word = noise ? 16'($urandom_range(16'hffff))
                   : build_reply(ang, 2'($urandom_range(3)), flaw);
      if (!noise && rx && flaw == FLAW_NONE) walk_angle[ch] = ang;
      send_reply(ch, rx, word);
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    // Let the count of owed results settle, drain them, then allow for the pipeline.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("encoder_word_check_and_turn_unwrap test passed");
    end else begin
      $display("encoder_word_check_and_turn_unwrap test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/ewctu_pkg.sv
rtl/ewctu_word_check.sv
rtl/ewctu_unwrap.sv
rtl/encoder_word_check_and_turn_unwrap.sv
rtl/ewctu_checker.sv
bench/encoder_word_check_and_turn_unwrap_checker.sv
bench/testbench.sv
